// ===== design/spo_pkg.sv =====
`timescale 1ns / 1ps

package spo_pkg;

  // Fraction bits of every Q-format value
  localparam int FRAC_BITS = 24;

  // Field widths
  localparam int FIELD_W    = 32;
  localparam int SCALE_W    = 25;
  localparam int SAMPLE_W   = FRAC_BITS + 2;
  localparam int STEP_W     = FRAC_BITS + 1;
  localparam int PHASE_W    = FRAC_BITS + 1;
  localparam int ACC_W      = FRAC_BITS + 3;
  localparam int PROD_W     = FIELD_W + SCALE_W + 1;
  localparam int STEP_SHIFT = 40 - FRAC_BITS;

  // Config port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SCALE_W;

  localparam longint ONE_CYCLE  = longint'(1) << FRAC_BITS;
  localparam longint HALF_CYCLE = longint'(1) << (FRAC_BITS - 1);

  localparam logic [SCALE_W-1:0] STEP_SCALE_RESET = SCALE_W'(89478);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SCALE = 1'b0,
    REG_SYNC_MODE  = 1'b1
  } cfg_reg_t;

endpackage

// ===== design/spo_if.sv =====
`timescale 1ns / 1ps

// Input sample channel
interface spo_in_if import spo_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] frequency;
  logic signed [FIELD_W-1:0] phase_mod;
  logic signed [FIELD_W-1:0] sync_value;
  logic                      set_phase;

  modport source (output valid, frequency, phase_mod, sync_value, set_phase,
                  input ready);
  modport sink   (input valid, frequency, phase_mod, sync_value, set_phase,
                  output ready);
endinterface

// Output sample channel
interface spo_out_if import spo_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

// ===== design/spo_step.sv =====
`timescale 1ns / 1ps

// Phase step: floor(frequency * scale / 2^STEP_SHIFT), clipped to +/- half a cycle
module spo_step import spo_pkg::*; (
  input  logic signed [FIELD_W-1:0] frequency,
  input  logic        [SCALE_W-1:0] step_scale,
  output logic signed [STEP_W-1:0]  step
);

  localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(HALF_CYCLE);
  localparam logic signed [PROD_W-1:0] NEG_HALF_P = PROD_W'(-HALF_CYCLE);

  logic signed [SCALE_W:0]  scale_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] shifted;

  assign scale_s = $signed({1'b0, step_scale});
  assign prod    = frequency * scale_s;
  // arithmetic shift rounds toward minus infinity
  assign shifted = prod >>> STEP_SHIFT;

  always_comb begin
    if (shifted > HALF_P) begin
      step = STEP_W'(HALF_CYCLE);
    end else if (shifted < NEG_HALF_P) begin
      step = STEP_W'(-HALF_CYCLE);
    end else begin
      step = shifted[STEP_W-1:0];
    end
  end

endmodule

// ===== design/sawtooth_phase_oscillator.sv =====
`timescale 1ns / 1ps
// Path: an input transaction is registered in stage 1, then stage 2, then the output register.
// Throughput: one transaction per cycle while the output is taken; three register stages
// (input, step, output) each advance when the next one is free, so while a result waits
// on the output the input still takes up to two more transactions before ready drops.
// Step multiply sits in the first stage, the phase update loop in the second.
// Reset (rst, synchronous): phase and previous offset zero, step_scale 89478, sync off.
module sawtooth_phase_oscillator import spo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  spo_in_if.sink                in_chan,
  spo_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Config registers
  logic [SCALE_W-1:0] step_scale;
  logic               sync_mode;

  // Stage 1: registered input
  logic                      s1_v;
  logic signed [FIELD_W-1:0] s1_freq;
  logic signed [FIELD_W-1:0] s1_offset;
  logic signed [FIELD_W-1:0] s1_sync;
  logic                      s1_set;
  logic signed [STEP_W-1:0]  s1_step;

  // Stage 2: step ready, phase update
  logic                      s2_v;
  logic signed [STEP_W-1:0]  s2_step;
  logic signed [FIELD_W-1:0] s2_offset;
  logic signed [FIELD_W-1:0] s2_sync;
  logic                      s2_set;

  // Output register
  logic                       out_v;
  logic signed [SAMPLE_W-1:0] out_sample;

  // Oscillator state
  logic signed [ACC_W-1:0]   phase_acc;
  logic signed [FIELD_W-1:0] prev_offset;

  // Flow control
  logic out_free, s2_free, s1_free, s2_fire, in_fire;

  assign out_free = !out_v || out_chan.ready;
  assign s2_fire  = s2_v && out_free;
  assign s2_free  = !s2_v || out_free;
  assign s1_free  = !s1_v || s2_free;
  assign in_fire  = in_chan.valid && s1_free;

  assign in_chan.ready  = s1_free;
  assign out_chan.valid = out_v;
  assign out_chan.sample = out_sample;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_scale <= STEP_SCALE_RESET;
      sync_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_SCALE: step_scale <= cfg_data[SCALE_W-1:0];
        REG_SYNC_MODE:  sync_mode  <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  spo_step u_step (
    .frequency  (s1_freq),
    .step_scale (step_scale),
    .step       (s1_step)
  );

  // Phase update for the item in stage 2
  logic [FRAC_BITS-1:0]      wrap_base;
  logic [FRAC_BITS-1:0]      wrapped;
  logic                      sync_hit;
  logic [PHASE_W-1:0]        phase;
  logic signed [SAMPLE_W-1:0] sample_next;
  logic signed [ACC_W-1:0]   acc_next;

  // only the fraction survives the modulo-one wrap
  assign wrap_base = (s2_set && !sync_mode) ? s2_sync[FRAC_BITS-1:0]
                                            : phase_acc[FRAC_BITS-1:0];
  assign wrapped   = wrap_base + s2_offset[FRAC_BITS-1:0] - prev_offset[FRAC_BITS-1:0];
  assign sync_hit  = sync_mode && (s2_sync > 0) && (s2_sync <= FIELD_W'(ONE_CYCLE));
  assign phase     = sync_hit ? s2_sync[PHASE_W-1:0] : {1'b0, wrapped};
  assign sample_next = $signed(SAMPLE_W'(ONE_CYCLE) - {phase, 1'b0});
  assign acc_next    = $signed(ACC_W'({1'b0, phase})) + ACC_W'(s2_step);

  // Pipeline valids and state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v        <= 1'b0;
      s2_v        <= 1'b0;
      out_v       <= 1'b0;
      phase_acc   <= '0;
      prev_offset <= '0;
    end else begin
      if (s1_free) s1_v <= in_chan.valid;
      if (s2_free) s2_v <= s1_v;
      if (out_free) out_v <= s2_v;
      if (s2_fire) begin
        phase_acc   <= acc_next;
        prev_offset <= s2_offset;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_freq   <= in_chan.frequency;
      s1_offset <= in_chan.phase_mod;
      s1_sync   <= in_chan.sync_value;
      s1_set    <= in_chan.set_phase;
    end
    if (s1_v && s2_free) begin
      s2_step   <= s1_step;
      s2_offset <= s1_offset;
      s2_sync   <= s1_sync;
      s2_set    <= s1_set;
    end
    if (s2_fire) begin
      out_sample <= sample_next;
    end
  end

  // Checks
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    (phase_acc >= ACC_W'(-HALF_CYCLE)) && (phase_acc <= ACC_W'(ONE_CYCLE + HALF_CYCLE)))
    else $error("phase accumulator out of range");

  a_step_clip: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> (s2_step >= STEP_W'(-HALF_CYCLE)) && (s2_step <= STEP_W'(HALF_CYCLE)))
    else $error("phase step not clipped");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_sample >= SAMPLE_W'(-ONE_CYCLE)) && (out_sample <= SAMPLE_W'(ONE_CYCLE)))
    else $error("sample out of range");

  a_s2_moves: assert property (@(posedge clk) disable iff (rst)
    s2_fire |=> out_v)
    else $error("stage 2 transaction lost");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !s1_v && !s2_v && !out_v)
    else $error("pipeline not empty after reset");

endmodule

// ===== tb/sv/tb_sawtooth_phase_oscillator.sv =====
`timescale 1ns / 1ps

module tb_sawtooth_phase_oscillator;
  import spo_pkg::*;

  localparam int STALL_LIMIT      = 2000;
  localparam int ITEMS_PER_SETTING = 112;
  localparam int NUM_SETTINGS     = 9;

  typedef logic signed [FIELD_W-1:0]  field_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    field_t frequency;
    field_t phase_mod;
    field_t sync_value;
    logic   set_phase;
  } osc_item_t;

  // Tracks oscillator state, predicts each sample, checks outputs in order
  class sawtooth_checker;
    logic [SCALE_W-1:0] step_scale;
    logic               sync_mode;
    longint             phase_acc;
    longint             prev_offset;
    sample_t            expected_samples[$];
    int                 mismatches;

    function new();
      step_scale  = STEP_SCALE_RESET;
      sync_mode   = 1'b0;
      phase_acc   = 0;
      prev_offset = 0;
      mismatches  = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_STEP_SCALE: step_scale = value[SCALE_W-1:0];
        REG_SYNC_MODE:  sync_mode  = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    function void predict_sample(osc_item_t it);
      longint step;
      longint dev;
      longint ph;
      // step = floor(freq * scale / 2^STEP_SHIFT), clipped to half a cycle
      step = (longint'(it.frequency) * longint'(step_scale)) >>> STEP_SHIFT;
      if (step > HALF_CYCLE) step = HALF_CYCLE;
      if (step < -HALF_CYCLE) step = -HALF_CYCLE;

      dev = longint'(it.phase_mod) - prev_offset;
      ph  = phase_acc;
      // hard sync only for a sync value in (0,1]
      if (sync_mode && it.sync_value > 0 && longint'(it.sync_value) <= ONE_CYCLE) begin
        ph = longint'(it.sync_value);
      end else begin
        if (!sync_mode && it.set_phase) ph = longint'(it.sync_value) & (ONE_CYCLE - 1);
        ph = (ph + dev) & (ONE_CYCLE - 1);
      end

      expected_samples.push_back(sample_t'(ONE_CYCLE - 2 * ph));
      phase_acc   = ph + step;
      prev_offset = longint'(it.phase_mod);
    endfunction

    function void check_sample(sample_t actual);
      sample_t want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        $display("%0t: sample, expected none, actual %0d", $time, actual);
        return;
      end
      want = expected_samples.pop_front();
      if (actual !== want) begin
        mismatches++;
        $display("%0t: sample, expected %0d, actual %0d", $time, want, actual);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int     in_idle_pct;
  int     out_idle_pct;
  int     stall_cycles;
  field_t offset_track;

  sawtooth_checker sb = new();

  spo_in_if  in_chan();
  spo_out_if out_chan();

  sawtooth_phase_oscillator dut (
    .clk       (clk),
    .rst       (rst),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output backpressure, transaction monitors and stall watchdog
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= out_idle_pct);
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) sb.check_sample(out_chan.sample);
      if (in_chan.valid && in_chan.ready)
        sb.predict_sample(osc_item_t'{in_chan.frequency, in_chan.phase_mod,
                                      in_chan.sync_value, in_chan.set_phase});
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic osc_item_t make_item(int f, int o, int s, bit p);
    osc_item_t it;
    it.frequency  = f;
    it.phase_mod  = o;
    it.sync_value = s;
    it.set_phase  = p;
    return it;
  endfunction

  // Mostly audio-range frequencies and small offset moves, plus full-range noise
  function automatic osc_item_t random_osc_item();
    osc_item_t it;
    int        pick;
    pick = $urandom_range(9);
    if (pick < 5) it.frequency = $urandom_range(20000 * 256);
    else if (pick < 7) it.frequency = $urandom_range(32'h00FF_FFFF);
    else if (pick < 9) it.frequency = $urandom();
    else it.frequency = ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (pick < 7 && $urandom_range(1) != 0) it.frequency = -it.frequency;

    pick = $urandom_range(9);
    if (pick < 6)
      it.phase_mod = offset_track + (int'($urandom_range(32'h01FF_FFFF)) - 32'sh0100_0000);
    else if (pick == 6) it.phase_mod = offset_track;
    else if (pick < 9) it.phase_mod = $urandom();
    else it.phase_mod = ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    offset_track = it.phase_mod;

    // sync values around the (0,1] window, at its edges, and anywhere
    pick = $urandom_range(15);
    if (pick < 3) it.sync_value = $urandom_range(int'(ONE_CYCLE), 1);
    else if (pick == 3) it.sync_value = field_t'(ONE_CYCLE);
    else if (pick == 4) it.sync_value = '0;
    else if (pick < 9) it.sync_value = int'($urandom_range(32'h0200_0000)) - 32'sh0080_0000;
    else it.sync_value = $urandom();

    it.set_phase = ($urandom_range(3) == 0);
    return it;
  endfunction

  task automatic send_item(input osc_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.frequency  <= it.frequency;
    in_chan.phase_mod  <= it.phase_mod;
    in_chan.sync_value <= it.sync_value;
    in_chan.set_phase  <= it.set_phase;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Hold input idle until every predicted sample has come out
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic apply_config(input logic [SCALE_W-1:0] scale, input logic mode);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP_SCALE;
    cfg_data  <= CFG_DATA_W'(scale);
    @(posedge clk);
    sb.set_reg(REG_STEP_SCALE, CFG_DATA_W'(scale));
    cfg_index <= REG_SYNC_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    sb.set_reg(REG_SYNC_MODE, CFG_DATA_W'(mode));
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [SCALE_W-1:0] scale_list [NUM_SETTINGS] =
      '{25'd89478, 25'd89478, 25'd1, 25'd16777216, 25'd0, 25'h1FF_FFFF, 25'd44739, 25'd0, 25'd0};
    logic               mode_list [NUM_SETTINGS] =
      '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    logic [SCALE_W-1:0] cur_scale;

    in_idle_pct  = 22;
    out_idle_pct = 52;
    offset_track = '0;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_STEP_SCALE;
    cfg_data           <= '0;
    in_chan.valid      <= 1'b0;
    in_chan.frequency  <= '0;
    in_chan.phase_mod  <= '0;
    in_chan.sync_value <= '0;
    in_chan.set_phase  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, phase-set mode
    send_item(make_item(0, 0, 0, 0));
    send_item(make_item(440 * 256, 0, 0, 0));
    send_item(make_item(32'h7FFF_FFFF, 0, 0, 0));          // step clips high
    send_item(make_item(32'h8000_0000, 0, 0, 0));          // step clips low
    send_item(make_item(1000 * 256, 32'h7FFF_FFFF, 0, 0)); // huge offset jump wraps
    send_item(make_item(1000 * 256, 32'h8000_0000, 0, 0)); // huge negative jump
    send_item(make_item(1000 * 256, 32'h8000_0000, 32'h00C0_0000, 1));
    send_item(make_item(1000 * 256, 32'h8000_0000, 32'h8000_0001, 1));
    send_item(make_item(1000 * 256, 32'h8000_0000, 32'h7FFF_FFFF, 1));
    send_item(make_item(1000 * 256, 0, 32'h0100_0000, 1));
    send_item(make_item(1000 * 256, 0, 32'h0080_0000, 0)); // sync ignored in this mode

    // Directed: sync mode at full scale
    apply_config(25'd16777216, 1'b1);
    send_item(make_item(100, 0, 32'h0100_0000, 0));        // sync to exactly one
    send_item(make_item(100, 0, 0, 0));                    // wraps back from one
    send_item(make_item(100, 0, 1, 0));                    // smallest sync
    send_item(make_item(100, 0, 32'h0100_0001, 0));        // just above one: ignored
    send_item(make_item(100, 32'h0030_0000, -1, 1));       // negative sync, set ignored
    send_item(make_item(100, 32'h0050_0000, 32'h0040_0000, 1)); // offset moves under sync
    send_item(make_item(32'h7FFF_FFFF, 0, 0, 0));
    send_item(make_item(32'h8000_0000, 0, 0, 0));

    // Directed: zero scale, then the widest scale with rounding toward minus infinity
    apply_config(25'd0, 1'b0);
    send_item(make_item(32'h7FFF_FFFF, 32'h0020_0000, 0, 0));
    send_item(make_item(32'h8000_0000, 32'h0010_0000, 0, 0));
    apply_config(25'h1FF_FFFF, 1'b0);
    send_item(make_item(-1, 0, 0, 0));
    send_item(make_item(1, 0, 0, 0));
    send_item(make_item(-1, 0, 0, 0));
    offset_track = '0;

    // Random phases across settings and idle profiles
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      cur_scale = scale_list[p];
      if (p >= 7) cur_scale = SCALE_W'($urandom_range(16777216, 1));
      apply_config(cur_scale, mode_list[p]);
      if (p < 3) begin
        in_idle_pct  = 22;
        out_idle_pct = 52;
      end else if (p < 6) begin
        in_idle_pct  = 52;
        out_idle_pct = 22;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if ($urandom_range(59) == 0) wait_drained();
        send_item(random_osc_item());
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sawtooth_phase_oscillator.f =====
design/spo_pkg.sv
design/spo_if.sv
design/spo_step.sv
design/sawtooth_phase_oscillator.sv
tb/sv/tb_sawtooth_phase_oscillator.sv
